// ----- rtl/cfm_pkg.sv -----
// Shared types and constants for the capture frequency meter.
// No dependencies; imported by cfm_divider and capture_frequency_meter_unit.
package cfm_pkg;

    localparam int CHANNELS     = 4;
    localparam int CH_W         = 2;
    localparam int CNT_W        = 16;   // capture counter width
    localparam int CLK_W        = 24;   // prescaled clock register width
    localparam int GAIN_W       = 16;
    localparam int FREQ_W       = 16;
    localparam int CFG_IDX_W    = 2;
    localparam int DIV_STEPS    = CLK_W;
    localparam int DIV_CNT_W    = $clog2(DIV_STEPS);
    localparam int FREQ_SHIFT   = 2;    // divide quotient by 4
    localparam int RPM_FACTOR   = 60;
    localparam int SPEED_SHIFT  = 8;    // Q8.8 gain

    localparam logic [CFG_IDX_W-1:0] REG_AUTO_RELOAD     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRESCALED_CLOCK = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_GAIN      = 2'd2;

    localparam logic [CNT_W-1:0]  AUTO_RELOAD_RST     = 16'd65535;
    localparam logic [CLK_W-1:0]  PRESCALED_CLOCK_RST = 24'd24000;
    localparam logic [GAIN_W-1:0] SPEED_GAIN_RST      = 16'd1447;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DIV,
        ST_SPD_CH,
        ST_SPD_F0,
        ST_SPD_F1,
        ST_OUT
    } cfm_state_t;

    typedef struct packed {
        logic             start;
        logic [CLK_W-1:0] dividend;
        logic [CNT_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [CLK_W-1:0] quotient;
    } div_rsp_t;

endpackage

// ----- rtl/capture_frequency_meter_unit.sv -----
// Capture frequency meter, top level: sequencer, channel state, shared multiplier.
// Depends on cfm_pkg and cfm_divider.
// Sequence: a capture on an armed channel with a usable period goes from acceptance through
//   evaluate, the divider, the multiplies for this channel, front left and front right, and
//   output to the result register; an arming capture or an error result skips the divider.
// Flow: one transaction at a time; s_tready is high only when idle, so the next
//   transaction is taken only after the result has been loaded into the output
//   register, which waits while a held result is not yet taken by m_tready.
// Reset (rst_n, async, active low): config registers to defaults, channel state
//   and the output valid flag cleared at once; no clearing pass.
module capture_frequency_meter_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    // input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [15:0]                   s_tdata,  // [15:0] capture_value
    input  logic [cfm_pkg::CH_W-1:0]      s_tuser,  // [1:0] channel
    // result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [63:0]                   m_tdata,  // [15:0] frequency, [31:16] rpm,
                                                    // [47:32] wheel_speed,
                                                    // [63:48] front_mean_speed
    output logic [3:0]                    m_tuser,  // [1:0] out_channel, [2] measured,
                                                    // [3] error
    // configuration write port
    input  logic                          wr_en,
    input  logic [cfm_pkg::CFG_IDX_W-1:0] wr_index,
    input  logic [cfm_pkg::CLK_W-1:0]     wr_data
);
    import cfm_pkg::*;

    // configuration
    logic [CNT_W-1:0]  auto_reload_reg;
    logic [CLK_W-1:0]  prescaled_clock_reg;
    logic [GAIN_W-1:0] speed_gain_reg;

    // per-channel state
    logic [CHANNELS-1:0] pending_reg;
    logic [CNT_W-1:0]    first_reg [CHANNELS];
    logic [FREQ_W-1:0]   freq_reg  [CHANNELS];

    // working registers for the transaction in flight
    cfm_state_t        state_reg, state_next;
    logic [CH_W-1:0]   ch_reg;
    logic [CNT_W-1:0]  cap_reg;
    logic              measured_reg;
    logic              error_reg;
    logic [FREQ_W-1:0] spd_reg;
    logic [FREQ_W-1:0] front0_reg;
    logic [FREQ_W-1:0] front1_reg;

    // output register
    logic              m_tvalid_reg;
    logic [63:0]       m_tdata_reg;
    logic [3:0]        m_tuser_reg;

    // sequencer controls
    logic in_accept;
    logic do_eval;
    logic div_start;
    logic load_freq;
    logic load_spd;
    logic load_f0;
    logic load_f1;
    logic out_free;
    logic load_out;

    // period evaluation
    logic [CNT_W-1:0] first_cur;
    logic             pend_cur;
    logic [CNT_W:0]   wrap_sum;
    logic [CNT_W:0]   wrap_period;
    logic [CNT_W-1:0] period;
    logic             period_ok;

    // divider
    div_req_t div_req;
    div_rsp_t div_rsp;
    logic [CLK_W-FREQ_SHIFT-1:0] quo_scaled;
    logic [FREQ_W-1:0]           freq_sat;

    // shared speed multiplier
    logic [FREQ_W-1:0]        mul_freq;
    logic [FREQ_W+GAIN_W-1:0] mul_prod;
    logic [FREQ_W+GAIN_W-SPEED_SHIFT-1:0] mul_scaled;
    logic [FREQ_W-1:0]        mul_speed;

    // result assembly
    logic [FREQ_W-1:0]   freq_out;
    logic [FREQ_W+6:0]   rpm_full;
    logic [FREQ_W:0]     front_sum;

    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;

    // ---------------- configuration writes ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            auto_reload_reg     <= AUTO_RELOAD_RST;
            prescaled_clock_reg <= PRESCALED_CLOCK_RST;
            speed_gain_reg      <= SPEED_GAIN_RST;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_AUTO_RELOAD:     auto_reload_reg     <= wr_data[CNT_W-1:0];
                REG_PRESCALED_CLOCK: prescaled_clock_reg <= wr_data;
                REG_SPEED_GAIN:      speed_gain_reg      <= wr_data[GAIN_W-1:0];
                default:             ; // indexes past the list are ignored
            endcase
        end
    end

    // ---------------- period from the two captures ----------------
    // Wrapped case: reload - first + second, usable only when positive.
    // Such a period is always below reload, so it fits the counter width.
    assign first_cur   = first_reg[ch_reg];
    assign pend_cur    = pending_reg[ch_reg];
    assign wrap_sum    = {1'b0, auto_reload_reg} + {1'b0, cap_reg};
    assign wrap_period = wrap_sum - {1'b0, first_cur};

    always_comb
    begin
        period    = cap_reg - first_cur;
        period_ok = 1'b1;
        if (cap_reg < first_cur)
        begin
            period    = wrap_period[CNT_W-1:0];
            period_ok = (wrap_sum > {1'b0, first_cur});
        end
        else if (cap_reg == first_cur)
        begin
            period_ok = 1'b0;   // equal captures: no period
        end
    end

    // ---------------- divider: prescaled_clock / period ----------------
    assign div_req.start    = div_start;
    assign div_req.dividend = prescaled_clock_reg;
    assign div_req.divisor  = period;

    cfm_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // quotient / 4, saturated to 16 bits
    assign quo_scaled = div_rsp.quotient[CLK_W-1:FREQ_SHIFT];
    assign freq_sat   = (|quo_scaled[CLK_W-FREQ_SHIFT-1:FREQ_W]) ? {FREQ_W{1'b1}}
                                                                   : quo_scaled[FREQ_W-1:0];

    // ---------------- shared speed multiplier ----------------
    // One freq * gain per cycle: this channel, then front left, then front right.
    always_comb
    begin
        case (state_reg)
            ST_SPD_F0: mul_freq = freq_reg[0];
            ST_SPD_F1: mul_freq = freq_reg[1];
            default:   mul_freq = freq_reg[ch_reg];
        endcase
    end

    assign mul_prod   = mul_freq * speed_gain_reg;
    assign mul_scaled = mul_prod[FREQ_W+GAIN_W-1:SPEED_SHIFT];
    assign mul_speed  = (|mul_scaled[FREQ_W+GAIN_W-SPEED_SHIFT-1:FREQ_W]) ? {FREQ_W{1'b1}}
                                                                          : mul_scaled[FREQ_W-1:0];

    // ---------------- sequencer: next state ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                    state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                if (pend_cur && period_ok)
                    state_next = ST_DIV;
                else
                    state_next = ST_SPD_CH;
            end
            ST_DIV:
            begin
                if (div_rsp.done)
                    state_next = ST_SPD_CH;
            end
            ST_SPD_CH: state_next = ST_SPD_F0;
            ST_SPD_F0: state_next = ST_SPD_F1;
            ST_SPD_F1: state_next = ST_OUT;
            ST_OUT:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // ---------------- sequencer: controls ----------------
    always_comb
    begin
        s_tready  = 1'b0;
        do_eval   = 1'b0;
        div_start = 1'b0;
        load_freq = 1'b0;
        load_spd  = 1'b0;
        load_f0   = 1'b0;
        load_f1   = 1'b0;
        load_out  = 1'b0;
        case (state_reg)
            ST_IDLE:   s_tready = 1'b1;
            ST_EVAL:
            begin
                do_eval   = 1'b1;
                div_start = pend_cur && period_ok;
            end
            ST_DIV:    load_freq = div_rsp.done;
            ST_SPD_CH: load_spd  = 1'b1;
            ST_SPD_F0: load_f0   = 1'b1;
            ST_SPD_F1: load_f1   = 1'b1;
            ST_OUT:    load_out  = out_free;
            default:   ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // ---------------- channel state ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                first_reg[i] <= '0;
                freq_reg[i]  <= '0;
            end
        end
        else
        begin
            if (do_eval)
            begin
                // a capture on an unarmed channel arms it, a capture on an armed channel disarms it
                pending_reg[ch_reg] <= !pend_cur;
                if (!pend_cur)
                    first_reg[ch_reg] <= cap_reg;
            end
            if (load_freq)
                freq_reg[ch_reg] <= freq_sat;
        end
    end

    // ---------------- transaction working registers ----------------
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            ch_reg  <= s_tuser;
            cap_reg <= s_tdata[CNT_W-1:0];
        end
        if (do_eval)
        begin
            measured_reg <= pend_cur;
            error_reg    <= pend_cur && !period_ok;
        end
        if (load_spd)
            spd_reg <= mul_speed;
        if (load_f0)
            front0_reg <= mul_speed;
        if (load_f1)
            front1_reg <= mul_speed;
    end

    // ---------------- result assembly and output register ----------------
    assign freq_out  = freq_reg[ch_reg];
    assign rpm_full  = freq_out * 7'(RPM_FACTOR);
    assign front_sum = {1'b0, front0_reg} + {1'b0, front1_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (load_out)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            m_tdata_reg <= {front_sum[FREQ_W:1], spd_reg, rpm_full[FREQ_W-1:0], freq_out};
            m_tuser_reg <= {error_reg, measured_reg, ch_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// ----- rtl/cfm_divider.sv -----
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on cfm_pkg (widths, request/response structs).
module cfm_divider (
    input  logic              clk,
    input  logic              rst_n,
    input  cfm_pkg::div_req_t req,
    output cfm_pkg::div_rsp_t rsp
);
    import cfm_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0]     rem_reg;
    logic [CLK_W-1:0]     quo_reg;
    logic [CNT_W-1:0]     dvs_reg;

    logic [CNT_W:0]       shifted;
    logic [CNT_W:0]       diff;
    logic                 fits;

    assign shifted = {rem_reg, quo_reg[CLK_W-1]};
    assign diff    = shifted - {1'b0, dvs_reg};
    assign fits    = (shifted >= {1'b0, dvs_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            quo_reg <= req.dividend;
            dvs_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            // remainder stays below the divisor, so it fits CNT_W bits
            rem_reg <= fits ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
            quo_reg <= {quo_reg[CLK_W-2:0], fits};
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule
